// File: src/pteu_pkg.sv
package pteu_pkg;
	localparam int Capacity = 64;
	localparam int IdxW = 6;
	localparam int CntW = 7;

	typedef struct packed {
		logic        action;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] life_span;
		logic signed [31:0] size_factor;
		logic signed [31:0] time_step;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] inst_scale;
		logic signed [31:0] inst_x;
		logic signed [31:0] inst_y;
		logic signed [31:0] inst_z;
		logic        last_one;
	} out_word_t;

	localparam logic [1:0] RegGx = 2'd0;
	localparam logic [1:0] RegGy = 2'd1;
	localparam logic [1:0] RegGz = 2'd2;
	localparam logic signed [31:0] GyReset = -32'sd642253;

	// datapath command from the controller
	typedef struct packed {
		logic          emit_wr;  // write input word at wr_idx
		logic          ld_dt;    // capture dt of an accepted tick
		logic          rd_en;    // read entry rd_idx
		logic [IdxW-1:0] rd_idx;
		logic [1:0]    axis;     // axis processed this phase
		logic          ld_life;  // registered read data valid: compute life
		logic          do_v;     // compute v for axis
		logic          do_p;     // compute p for axis
		logic          wr_upd;   // write back survivor at wr_idx
		logic [IdxW-1:0] wr_idx;
		logic          out_ld;   // load output word from write data
	} cmd_t;

	typedef struct packed {
		logic alive;  // life after dt is positive
	} stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7fffffff;
		return s[31:0];
	endfunction

	// floor(p / 2^16) is an arithmetic shift
	function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
		logic signed [63:0] q;
		q = p >>> 16;
		return sat32(q);
	endfunction
endpackage

// File: src/pteu_ctrl.sv
module pteu_ctrl import pteu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_action,
	input  logic stage_ready,
	input  logic stage_full,
	output logic idle,
	input  stat_t stat,
	output cmd_t cmd
);
	typedef enum logic [2:0] {IDLE, RD, LIFE, AX, OUT, WAIT} state_t;
	state_t state_q;
	logic [CntW-1:0] count_q, rd_q, alive_q;
	logic [1:0] axis_q;
	logic       ph_q;

	assign idle     = (state_q == IDLE);
	assign in_ready = idle && !stage_full;

	always_comb begin
		cmd = '0;
		cmd.rd_idx = rd_q[IdxW-1:0];
		cmd.wr_idx = in_action ? alive_q[IdxW-1:0] : count_q[IdxW-1:0];
		cmd.axis = axis_q;
		cmd.emit_wr = idle && in_valid && in_ready && !in_action
			&& (count_q < CntW'(Capacity));
		cmd.ld_dt = idle && in_valid && in_ready && in_action;
		cmd.rd_en = (state_q == RD);
		cmd.ld_life = (state_q == LIFE);
		cmd.do_v = (state_q == AX) && !ph_q;
		cmd.do_p = (state_q == AX) && ph_q;
		cmd.wr_upd = (state_q == OUT);
		cmd.out_ld = (state_q == OUT) && stage_ready;
		if (state_q != IDLE) cmd.wr_idx = alive_q[IdxW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			rd_q <= '0;
			alive_q <= '0;
			axis_q <= '0;
			ph_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (in_valid && in_ready) begin
						if (!in_action) begin
							if (count_q < CntW'(Capacity)) count_q <= count_q + 1'b1;
						end else begin
							rd_q <= '0;
							alive_q <= '0;
							state_q <= (count_q == '0) ? IDLE : RD;
						end
					end
				end
				RD: state_q <= LIFE;
				LIFE: begin
					axis_q <= '0;
					ph_q <= 1'b0;
					state_q <= AX;
				end
				AX: begin
					if (!stat.alive) begin
						state_q <= WAIT;
					end else if (ph_q) begin
						ph_q <= 1'b0;
						if (axis_q == RegGz) state_q <= OUT;
						else axis_q <= axis_q + 1'b1;
					end else begin
						ph_q <= 1'b1;
					end
				end
				OUT: begin
					// hold until the staging register can take the word
					if (stage_ready) begin
						alive_q <= alive_q + 1'b1;
						state_q <= WAIT;
					end
				end
				WAIT: begin
					rd_q <= rd_q + 1'b1;
					state_q <= (rd_q + 1'b1 == count_q) ? IDLE : RD;
					if (rd_q + 1'b1 == count_q) count_q <= alive_q;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// File: src/pteu_dp.sv
module pteu_dp import pteu_pkg::*; (
	input  logic clk,
	input  in_word_t in_word,
	input  logic signed [31:0] grav_x,
	input  logic signed [31:0] grav_y,
	input  logic signed [31:0] grav_z,
	input  cmd_t cmd,
	output stat_t stat,
	output logic signed [31:0] o_scale,
	output logic signed [31:0] o_x,
	output logic signed [31:0] o_y,
	output logic signed [31:0] o_z
);
	logic [191:0] pv_mem [Capacity];
	logic [63:0]  ls_mem [Capacity];
	logic [191:0] pv_q;
	logic [63:0]  ls_q;
	logic signed [31:0] dt_q, life_q, scale_q, g_sel, mul_a, vn_q;
	logic signed [31:0] p_q [3];
	logic signed [31:0] v_q [3];
	logic signed [63:0] prod;
	logic alive_q;

	always_ff @(posedge clk) begin
		if (cmd.emit_wr) begin
			pv_mem[cmd.wr_idx] <= {in_word.pos_x, in_word.pos_y, in_word.pos_z,
				in_word.vel_x, in_word.vel_y, in_word.vel_z};
			ls_mem[cmd.wr_idx] <= {in_word.life_span, in_word.size_factor};
		end else if (cmd.wr_upd) begin
			pv_mem[cmd.wr_idx] <= {p_q[0], p_q[1], p_q[2], v_q[0], v_q[1], v_q[2]};
			ls_mem[cmd.wr_idx] <= {life_q, scale_q};
		end
		if (cmd.rd_en) begin
			pv_q <= pv_mem[cmd.rd_idx];
			ls_q <= ls_mem[cmd.rd_idx];
		end
	end

	always_comb begin
		case (cmd.axis)
			RegGx: g_sel = grav_x;
			RegGy: g_sel = grav_y;
			default: g_sel = grav_z;
		endcase
		mul_a = cmd.do_p ? vn_q : g_sel;
		prod = 64'(mul_a) * 64'(dt_q);
	end

	assign stat.alive = alive_q;

	always_ff @(posedge clk) begin
		if (cmd.ld_dt)
			dt_q <= in_word.time_step;
		if (cmd.ld_life) begin
			life_q <= sat32(64'($signed(ls_q[63:32])) - 64'(dt_q));
			alive_q <= sat32(64'($signed(ls_q[63:32])) - 64'(dt_q)) > 0;
			scale_q <= ls_q[31:0];
			p_q[0] <= pv_q[191:160]; p_q[1] <= pv_q[159:128]; p_q[2] <= pv_q[127:96];
			v_q[0] <= pv_q[95:64];   v_q[1] <= pv_q[63:32];   v_q[2] <= pv_q[31:0];
		end
		if (cmd.do_v) begin
			vn_q <= qadd(v_q[cmd.axis], qscale(prod));
			v_q[cmd.axis] <= qadd(v_q[cmd.axis], qscale(prod));
		end
		if (cmd.do_p) p_q[cmd.axis] <= qadd(p_q[cmd.axis], qscale(prod));
		// staged survivor, one word behind the output register
		if (cmd.out_ld) begin
			o_scale <= scale_q;
			o_x <= p_q[0]; o_y <= p_q[1]; o_z <= p_q[2];
		end
	end
endmodule

// File: src/particle_table_euler_update.sv
// Emit: accepted while idle and no word is staged; emits can follow back to back.
// Tick: each entry is read and its life reduced by dt; a survivor then has v and p
// stepped per axis, is written back compacted and staged; the final word is then flushed.
// Result words are staged one behind so the last flag can be set: a word leaves when
// the next survivor is staged or the sweep ends. Output stalls stretch the sweep.
// Reset clears the particle count and handshakes and loads gravity (y = GyReset, x, z zero);
// the table memory itself is not cleared.
module particle_table_euler_update import pteu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_word_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_word_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	logic signed [31:0] gx_q, gy_q, gz_q;
	cmd_t cmd;
	stat_t stat;
	logic idle;
	logic take;
	logic push_mid, push_last;
	logic pend_q, outv_q;
	logic signed [31:0] s_d, x_d, y_d, z_d;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0; gy_q <= GyReset; gz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegGx: gx_q <= cfg_data;
				RegGy: gy_q <= cfg_data;
				RegGz: gz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// staging register can take a new word
	assign take = !pend_q || !outv_q || out_ready;

	pteu_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_ready, .in_action(in_data.action),
		.stage_ready(take), .stage_full(pend_q), .idle, .stat, .cmd);

	pteu_dp u_dp (.clk, .in_word(in_data), .grav_x(gx_q), .grav_y(gy_q), .grav_z(gz_q),
		.cmd, .stat, .o_scale(s_d), .o_x(x_d), .o_y(y_d), .o_z(z_d));

	// a staged word goes out when the next one arrives, or flagged last once the
	// sweep is over
	assign push_mid  = cmd.out_ld && pend_q;
	assign push_last = pend_q && idle && (!outv_q || out_ready);
	assign out_valid = outv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; outv_q <= 1'b0;
		end else begin
			if (push_mid || push_last) outv_q <= 1'b1;
			else if (out_ready) outv_q <= 1'b0;
			if (cmd.out_ld) pend_q <= 1'b1;
			else if (push_last) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || push_last) out_data <= '{s_d, x_d, y_d, z_d, push_last};
	end

	ap_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_wr |-> in_valid) else $error("emit write without input");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_v |-> !in_ready) else $error("accepting during sweep");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while waiting");
endmodule
